/* hw/rtl/ptt_pkg.sv */
// shared types and constants of the periodic timer table
// no dependencies; used by the controller, the datapath and the top level

package ptt_pkg;

   // request commands
   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_POLL  = 2'd3
   } cmd_type;

   // response kinds
   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_FOUND     = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_FIRED     = 3'd4,
      KIND_NO_FIRE   = 3'd5
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // at most this many fired responses per poll
   localparam int unsigned MAX_REPORTS = 8;
   localparam int unsigned REP_W       = 4;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic add_commit;
      logic miss_load;
      logic found_commit;
      logic walk_inc;
      logic fire_reload;
      logic fire_report;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    walk_end;
      logic    id_match;
      logic    fire;
      logic    report_ok;
      logic    pend_valid;
      logic    out_free;
   } ctrl_status_type;

endpackage

/* hw/rtl/periodic_timer_table_top.sv */
// Periodic timer table, top level. One request is taken at a time: an add
// passes through the add and finish states, while a start, stop or poll
// reads each slot from the slot stores through a registered read port and
// checks it in the next cycle; a start or stop ends at the first slot whose
// id matches, and a poll checks every used slot. Each response waits in an
// output register while rsp_stall holds, and a second fired response of a
// poll waits there too, stretching the poll by the stalled cycles. A new
// request is taken as soon as the last response of the previous one sits
// in that register. Slot stores need no clearing after reset.
// depends on ptt_pkg, ptt_ctrl and ptt_datapath

module periodic_timer_table_top #(
   parameter int NUM_TIMERS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_now_ms,
   input  logic signed [15:0] req_timer_id,
   input  logic [31:0]        req_interval_ms,
   input  logic               req_enable_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic signed [15:0] rsp_event_id,
   output logic [2:0]         rsp_slot_index,
   output logic               rsp_last_of_run
);

   ptt_pkg::ctrl_cmd_type    ctrl_cmd;
   ptt_pkg::ctrl_status_type ctrl_status;

   // sequencer
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   // slot stores and response path
   ptt_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_now_ms      (req_now_ms),
      .req_timer_id    (req_timer_id),
      .req_interval_ms (req_interval_ms),
      .req_enable_now  (req_enable_now),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_event_id    (rsp_event_id),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (ctrl_cmd),
      .status          (ctrl_status)
   );

endmodule

/* hw/rtl/ptt_ram.sv */
// generic single write port ram with registered read
// no dependencies

module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

/* hw/rtl/ptt_ctrl.sv */
// controller state machine of the periodic timer table
// depends on ptt_pkg; drives the datapath through command signals

module ptt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_cmd,
   output logic                     req_stall,
   input  ptt_pkg::ctrl_status_type status,
   output ptt_pkg::ctrl_cmd_type    cmd
);

   ptt_pkg::state_type state_ff, state_in;
   logic               is_search;
   logic               fire_blocked;

   assign is_search    = (status.cmd == ptt_pkg::CMD_START) ||
                         (status.cmd == ptt_pkg::CMD_STOP);
   assign fire_blocked = status.fire && status.report_ok &&
                         status.pend_valid && !status.out_free;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (ptt_pkg::cmd_type'(req_cmd) == ptt_pkg::CMD_ADD) ?
                          ptt_pkg::ST_ADD : ptt_pkg::ST_READ;
            end
         end
         ptt_pkg::ST_ADD: begin
            state_in = ptt_pkg::ST_FINISH;
         end
         ptt_pkg::ST_READ: begin
            state_in = status.walk_end ? ptt_pkg::ST_FINISH : ptt_pkg::ST_CHECK;
         end
         ptt_pkg::ST_CHECK: begin
            if (is_search) begin
               state_in = status.id_match ? ptt_pkg::ST_FINISH : ptt_pkg::ST_READ;
            end else if (!fire_blocked) begin
               state_in = ptt_pkg::ST_READ;
            end
         end
         ptt_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ptt_pkg::ST_ADD: begin
            cmd.add_commit = 1'b1;
         end
         ptt_pkg::ST_READ: begin
            cmd.miss_load = status.walk_end && is_search;
         end
         ptt_pkg::ST_CHECK: begin
            if (is_search) begin
               cmd.found_commit = status.id_match;
               cmd.walk_inc     = !status.id_match;
            end else if (!fire_blocked) begin
               cmd.fire_reload = status.fire;
               cmd.fire_report = status.fire && status.report_ok;
               cmd.walk_inc    = 1'b1;
            end
         end
         ptt_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hw/rtl/ptt_datapath.sv */
// datapath of the periodic timer table: request registers, slot stores,
// walk counter, pending and output response registers
// depends on ptt_pkg and ptt_ram

module ptt_datapath #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_cmd,
   input  logic [31:0]              req_now_ms,
   input  logic signed [15:0]       req_timer_id,
   input  logic [31:0]              req_interval_ms,
   input  logic                     req_enable_now,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_kind,
   output logic signed [15:0]       rsp_event_id,
   output logic [2:0]               rsp_slot_index,
   output logic                     rsp_last_of_run,
   input  ptt_pkg::ctrl_cmd_type    cmd,
   output ptt_pkg::ctrl_status_type status
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);

   // request registers
   ptt_pkg::cmd_type   cmd_ff;
   logic [31:0]        now_ff;
   logic signed [15:0] id_ff;
   logic [31:0]        ivl_ff;
   logic               en_ff;

   // control registers
   logic [CW-1:0]             walk_ff, walk_in;
   logic [CW-1:0]             used_ff, used_in;
   logic [NUM_TIMERS-1:0]     enabled_ff, enabled_in;
   logic [ptt_pkg::REP_W-1:0] rep_ff, rep_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // response payload registers
   ptt_pkg::kind_type  pend_kind_ff, pend_kind_in;
   logic signed [15:0] pend_id_ff, pend_id_in;
   logic [2:0]         pend_slot_ff, pend_slot_in;
   ptt_pkg::kind_type  out_kind_ff, out_kind_in;
   logic signed [15:0] out_id_ff, out_id_in;
   logic [2:0]         out_slot_ff, out_slot_in;
   logic               out_last_ff, out_last_in;

   // slot stores
   logic [15:0]   rd_event_id;
   logic [31:0]   rd_interval;
   logic [31:0]   rd_last_time;
   logic [IW-1:0] walk_addr, used_addr, wr_addr;
   logic          ev_wr_en, lt_wr_en;

   logic          used_full, id_match, due, fire, out_free, push_pend;
   logic [CW+2:0] walk_wide, used_wide;
   logic [2:0]    walk_slot, used_slot;
   logic [31:0]   wrap_gap;
   logic [32:0]   due_sum;

   assign walk_addr = walk_ff[IW-1:0];
   assign used_addr = used_ff[IW-1:0];
   assign wr_addr   = cmd.add_commit ? used_addr : walk_addr;
   assign walk_wide = (CW + 3)'(walk_ff);
   assign used_wide = (CW + 3)'(used_ff);
   assign walk_slot = walk_wide[2:0];
   assign used_slot = used_wide[2:0];
   assign used_full = (used_ff == CW'(NUM_TIMERS));

   assign ev_wr_en = cmd.add_commit && !used_full;
   assign lt_wr_en = (ev_wr_en && en_ff) ||
                     (cmd.found_commit && (cmd_ff == ptt_pkg::CMD_START)) ||
                     cmd.fire_reload;

   ptt_ram #(.WIDTH(16), .DEPTH(NUM_TIMERS)) u_event_id_ram (
      .clock      (clock),
      .wr_en      (ev_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (id_ff),
      .rd_addr    (walk_addr),
      .rd_data_ff (rd_event_id)
   );

   ptt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_interval_ram (
      .clock      (clock),
      .wr_en      (ev_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (ivl_ff),
      .rd_addr    (walk_addr),
      .rd_data_ff (rd_interval)
   );

   ptt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_last_time_ram (
      .clock      (clock),
      .wr_en      (lt_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (now_ff),
      .rd_addr    (walk_addr),
      .rd_data_ff (rd_last_time)
   );

   // due test, wrapped and unwrapped cases side by side
   assign wrap_gap = (32'hFFFF_FFFF - rd_last_time) + now_ff;
   assign due_sum  = {1'b0, rd_last_time} + {1'b0, rd_interval};
   assign due      = (now_ff < rd_last_time) ? (wrap_gap >= rd_interval) :
                                               (due_sum <= {1'b0, now_ff});
   assign fire     = enabled_ff[walk_addr] && due;
   assign id_match = (rd_event_id == id_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push_pend = cmd.fire_report && pend_valid_ff;

   // status to the controller
   always_comb begin
      status.cmd        = cmd_ff;
      status.walk_end   = (walk_ff >= used_ff);
      status.id_match   = id_match;
      status.fire       = fire;
      status.report_ok  = (rep_ff < ptt_pkg::REP_W'(ptt_pkg::MAX_REPORTS));
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= ptt_pkg::cmd_type'(req_cmd);
         now_ff <= req_now_ms;
         id_ff  <= req_timer_id;
         ivl_ff <= req_interval_ms;
         en_ff  <= req_enable_now;
      end
   end

   // walk counter, fill count, enables and report count
   always_comb begin
      walk_in    = walk_ff;
      used_in    = used_ff;
      enabled_in = enabled_ff;
      rep_in     = rep_ff;
      if (cmd.capture) begin
         walk_in = '0;
         rep_in  = '0;
      end
      if (cmd.walk_inc) begin
         walk_in = walk_ff + CW'(1);
      end
      if (ev_wr_en) begin
         used_in               = used_ff + CW'(1);
         enabled_in[used_addr] = en_ff;
      end
      if (cmd.found_commit) begin
         enabled_in[walk_addr] = (cmd_ff == ptt_pkg::CMD_START);
      end
      if (cmd.fire_report) begin
         rep_in = rep_ff + ptt_pkg::REP_W'(1);
      end
   end

   // pending response, held until the next one shows whether it is last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_slot_in  = pend_slot_ff;
      if (cmd.add_commit) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = used_full ? ptt_pkg::KIND_FULL : ptt_pkg::KIND_ADDED;
         pend_id_in    = id_ff;
         pend_slot_in  = used_full ? 3'd0 : used_slot;
      end else if (cmd.miss_load) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = ptt_pkg::KIND_NOT_FOUND;
         pend_id_in    = id_ff;
         pend_slot_in  = 3'd0;
      end else if (cmd.found_commit) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = ptt_pkg::KIND_FOUND;
         pend_id_in    = rd_event_id;
         pend_slot_in  = walk_slot;
      end else if (cmd.fire_report) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = ptt_pkg::KIND_FIRED;
         pend_id_in    = rd_event_id;
         pend_slot_in  = walk_slot;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_slot_in  = out_slot_ff;
      out_last_in  = out_last_ff;
      if (push_pend) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_id_in    = pend_id_ff;
         out_slot_in  = pend_slot_ff;
         out_last_in  = 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = pend_valid_ff ? pend_kind_ff : ptt_pkg::KIND_NO_FIRE;
         out_id_in    = pend_valid_ff ? pend_id_ff : 16'sd0;
         out_slot_in  = pend_valid_ff ? pend_slot_ff : 3'd0;
         out_last_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff       <= '0;
         used_ff       <= '0;
         enabled_ff    <= '0;
         rep_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         walk_ff       <= walk_in;
         used_ff       <= used_in;
         enabled_ff    <= enabled_in;
         rep_ff        <= rep_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_slot_ff <= pend_slot_in;
      out_kind_ff  <= out_kind_in;
      out_id_ff    <= out_id_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_event_id    = out_id_ff;
   assign rsp_slot_index  = out_slot_ff;
   assign rsp_last_of_run = out_last_ff;

   // fill count stays within the table
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(NUM_TIMERS))
      else $error("slot fill count beyond table size");

   // a poll never reports more than the limit
   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_ff <= ptt_pkg::REP_W'(ptt_pkg::MAX_REPORTS))
      else $error("too many fired responses in one poll");

   // a pending response is only replaced when it can move to the output
   a_pend_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.fire_report && pend_valid_ff) |-> out_free)
      else $error("pending response overwritten");

   // finishing a run always presents a last response next cycle
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && out_last_ff && !pend_valid_ff))
      else $error("run ended without a last response");

endmodule
